### hw/rtl/u8250_pkg.sv
// ----------------------------------------------------------------------------
// u8250_pkg: shared types and constants of the 8250 register model
// Item and result beats, function codes, register offsets, fixed patterns.
// ----------------------------------------------------------------------------
package u8250_pkg;

    typedef enum logic [1:0] {
        FUNC_READ  = 2'd0,
        FUNC_WRITE = 2'd1,
        FUNC_RX    = 2'd2,
        FUNC_NONE  = 2'd3
    } func_t;

    localparam logic [2:0] OFF_RBR_THR = 3'd0;
    localparam logic [2:0] OFF_IER     = 3'd1;
    localparam logic [2:0] OFF_IIR     = 3'd2;
    localparam logic [2:0] OFF_LCR     = 3'd3;
    localparam logic [2:0] OFF_MCR     = 3'd4;
    localparam logic [2:0] OFF_LSR     = 3'd5;
    localparam logic [2:0] OFF_MSR     = 3'd6;
    localparam logic [2:0] OFF_SCR     = 3'd7;

    localparam int unsigned DLAB_POS  = 7;
    localparam logic [7:0]  LSR_BASE  = 8'h60;
    localparam logic [7:0]  MSR_VALUE = 8'hb0;

    typedef struct packed {
        logic [1:0] func;
        logic [2:0] offset;
        logic [7:0] write_data;
        logic [7:0] rx_byte;
    } item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       irq_level;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       rx_accepted;
    } result_t;

endpackage

### hw/rtl/u8250_regs.sv
// ----------------------------------------------------------------------------
// u8250_regs: UART register file and access decode
// Applies one beat per strobe to the register state and forms its result.
// ----------------------------------------------------------------------------
module u8250_regs (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               step,
    input  u8250_pkg::item_t   item,
    output u8250_pkg::result_t res
);

    logic [7:0] divisor_low_reg,   divisor_low_next;
    logic [7:0] divisor_high_reg,  divisor_high_next;
    logic [7:0] line_control_reg,  line_control_next;
    logic [7:0] int_enable_reg,    int_enable_next;
    logic [7:0] modem_control_reg, modem_control_next;
    logic [1:0] pending_reg,       pending_next;
    logic [7:0] rx_holding_reg,    rx_holding_next;
    logic       dlab;

    assign dlab = line_control_reg[u8250_pkg::DLAB_POS];

    always_comb begin
        divisor_low_next   = divisor_low_reg;
        divisor_high_next  = divisor_high_reg;
        line_control_next  = line_control_reg;
        int_enable_next    = int_enable_reg;
        modem_control_next = modem_control_reg;
        pending_next       = pending_reg;
        rx_holding_next    = rx_holding_reg;
        res                = '0;
        if (step) begin
            unique case (u8250_pkg::func_t'(item.func))
                u8250_pkg::FUNC_READ: begin
                    unique case (item.offset)
                        u8250_pkg::OFF_RBR_THR: begin
                            if (dlab) begin
                                res.read_data = divisor_low_reg;
                            end else begin
                                res.read_data   = rx_holding_reg;
                                pending_next[0] = 1'b0;
                            end
                        end
                        u8250_pkg::OFF_IER: begin
                            res.read_data = dlab ? divisor_high_reg : int_enable_reg;
                        end
                        u8250_pkg::OFF_IIR: begin
                            res.read_data = {7'd0, ~|(int_enable_reg[1:0] & pending_reg)};
                        end
                        u8250_pkg::OFF_LCR: res.read_data = line_control_reg;
                        u8250_pkg::OFF_MCR: res.read_data = modem_control_reg;
                        u8250_pkg::OFF_LSR: begin
                            res.read_data = u8250_pkg::LSR_BASE | {7'd0, pending_reg[0]};
                        end
                        u8250_pkg::OFF_MSR: res.read_data = u8250_pkg::MSR_VALUE;
                        default:            res.read_data = 8'd0;
                    endcase
                end
                u8250_pkg::FUNC_WRITE: begin
                    unique case (item.offset)
                        u8250_pkg::OFF_RBR_THR: begin
                            if (dlab) begin
                                divisor_low_next = item.write_data;
                            end else begin
                                res.tx_valid = 1'b1;
                                res.tx_byte  = item.write_data;
                            end
                        end
                        u8250_pkg::OFF_IER: begin
                            if (dlab) begin
                                divisor_high_next = item.write_data;
                            end else begin
                                int_enable_next = item.write_data;
                                pending_next[1] = item.write_data[1];
                            end
                        end
                        u8250_pkg::OFF_LCR: line_control_next  = item.write_data;
                        u8250_pkg::OFF_MCR: modem_control_next = item.write_data;
                        default: ;
                    endcase
                end
                u8250_pkg::FUNC_RX: begin
                    if (!pending_reg[0]) begin
                        rx_holding_next = item.rx_byte;
                        pending_next[0] = 1'b1;
                        res.rx_accepted = 1'b1;
                    end
                end
                u8250_pkg::FUNC_NONE: ;
            endcase
        end
        res.irq_level = |(int_enable_next[1:0] & pending_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            divisor_low_reg   <= '0;
            divisor_high_reg  <= '0;
            line_control_reg  <= '0;
            int_enable_reg    <= '0;
            modem_control_reg <= '0;
            pending_reg       <= '0;
            rx_holding_reg    <= '0;
        end else begin
            divisor_low_reg   <= divisor_low_next;
            divisor_high_reg  <= divisor_high_next;
            line_control_reg  <= line_control_next;
            int_enable_reg    <= int_enable_next;
            modem_control_reg <= modem_control_next;
            pending_reg       <= pending_next;
            rx_holding_reg    <= rx_holding_next;
        end
    end

    a_rx_sets_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        step && res.rx_accepted |=> pending_reg[0])
        else $error("accepted byte did not set data ready");

    a_rx_full_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        step && item.func == u8250_pkg::FUNC_RX && pending_reg[0]
        |=> $stable(rx_holding_reg))
        else $error("byte overwrote a full holding register");

    a_rbr_read_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        step && item.func == u8250_pkg::FUNC_READ
        && item.offset == u8250_pkg::OFF_RBR_THR && !dlab |=> !pending_reg[0])
        else $error("receive buffer read left data ready set");

    a_tx_only_thr: assert property (@(posedge aclk) disable iff (!aresetn)
        step && res.tx_valid |-> item.func == u8250_pkg::FUNC_WRITE
        && item.offset == u8250_pkg::OFF_RBR_THR && !dlab)
        else $error("transmit beat from a non-THR access");

endmodule

### hw/rtl/u8250_out.sv
// ----------------------------------------------------------------------------
// u8250_out: result register
// Holds one result beat until the sink takes it; loads a new one on the
// same edge the old one leaves.
// ----------------------------------------------------------------------------
module u8250_out (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               load,
    input  u8250_pkg::result_t res_in,
    output logic               free,
    output logic               m_valid,
    input  logic               m_ready,
    output u8250_pkg::result_t res_out
);

    logic               valid_reg, valid_next;
    u8250_pkg::result_t data_reg;

    assign free       = !valid_reg || m_ready;
    assign valid_next = load || (valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= res_in;
        end
    end

    assign m_valid = valid_reg;
    assign res_out = data_reg;

endmodule

### hw/rtl/uart_8250_register_model.sv
// ----------------------------------------------------------------------------
// uart_8250_register_model: simplified 8250 UART register file
// Register reads, register writes and received bytes in; one result per beat.
// ----------------------------------------------------------------------------
// Each input beat is a register read, a register write or an arriving receive
// byte, and produces exactly one result beat. A beat is applied to the
// register state on the edge it is accepted and its result is registered on
// that same edge, so the result appears in the cycle after. One beat per cycle
// is sustained; the input stalls only while the result register holds a beat
// the sink has not taken. irq_level reflects the state after the beat.
module uart_8250_register_model (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_func,
    input  logic [2:0] s_offset,
    input  logic [7:0] s_write_data,
    input  logic [7:0] s_rx_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_read_data,
    output logic       m_irq_level,
    output logic       m_tx_valid,
    output logic [7:0] m_tx_byte,
    output logic       m_rx_accepted
);

    u8250_pkg::item_t   item;
    u8250_pkg::result_t res;
    u8250_pkg::result_t res_q;
    logic               step;
    logic               free;

    assign item.func       = s_func;
    assign item.offset     = s_offset;
    assign item.write_data = s_write_data;
    assign item.rx_byte    = s_rx_byte;

    assign s_ready = free;
    assign step    = s_valid && free;

    u8250_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .item    (item),
        .res     (res)
    );

    u8250_out u_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (step),
        .res_in  (res),
        .free    (free),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .res_out (res_q)
    );

    assign m_read_data   = res_q.read_data;
    assign m_irq_level   = res_q.irq_level;
    assign m_tx_valid    = res_q.tx_valid;
    assign m_tx_byte     = res_q.tx_byte;
    assign m_rx_accepted = res_q.rx_accepted;

endmodule
